/* rtl/mt_pkg.sv */
// Shared constants and types for the Mersenne Twister generator.
package mt_pkg;

    localparam int IDX_W = 10;

    localparam logic [IDX_W-1:0] STATE_WORDS  = 10'd624;
    localparam logic [IDX_W-1:0] LAST_WORD    = 10'd623;
    localparam logic [IDX_W-1:0] TWIST_OFFSET = 10'd397;
    localparam logic [IDX_W-1:0] POS_UNSEEDED = 10'd625;

    localparam logic [31:0] TW_XOR_CONST = 32'h9908_b0df;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [31:0] LCG_MUL      = 32'd69069;
    localparam logic [31:0] DEFAULT_SEED = 32'd4357;

    localparam logic [1:0] MODE_DRAW = 2'd0;
    localparam logic [1:0] MODE_SEED = 2'd1;
    localparam logic [1:0] MODE_LOAD = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SEED,
        ST_TW_PRIME,
        ST_TW_LOAD,
        ST_TW_RUN,
        ST_RD,
        ST_OUT
    } mt_state_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [31:0]      wdata;
        logic [IDX_W-1:0] raddr_a;
        logic [IDX_W-1:0] raddr_b;
    } mt_ram_req_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [31:0]      data;
        logic             done;
    } mt_seed_wr_t;

endpackage

/* rtl/mersenne_twister_generator.sv */
// Mersenne Twister generator: control, twist pipeline, tempering and output word.
//
// Input channel (in_valid/in_stall) carries one word: mode, value, word_index.
//   mode 0 draws one tempered 32-bit word, returned on the output channel.
//   mode 1 seeds the 624-word state memory from value (no output word).
//   mode 2 writes value into state word word_index (no output word);
//   an index of 624 or more and mode 3 are dropped.
// A word is taken only while the controller is idle; in_stall is high otherwise.
// A draw that needs no twist steps through idle, dispatch, read and output, and the
// next word is taken only after the controller returns to idle.
// When all 624 words are used, or after a load or seed, the next draw first runs
// the twist pass: one state word per cycle through the memory's single write
// port with two read ports. Seeding runs two congruential steps per word through
// one multiplier. A draw before any seed first seeds with 4357, then twists.
// Output channel (out_valid/out_stall) is a register: a finished word waits there
// while out_stall is high, and the next input word is still taken meanwhile; a
// second draw waits for the register to empty.
// Reset clears control and marks the generator unseeded; memory is not cleared.
module mersenne_twister_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [31:0] value,
    input  logic [9:0]  word_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] random_word
);

    mt_pkg::mt_state_t   state_reg, state_next;
    mt_pkg::mt_ram_req_t ram_req;
    mt_pkg::mt_seed_wr_t seed_wr;

    logic [31:0] rd_a;
    logic [31:0] rd_b;

    logic [1:0]               mode_reg;
    logic [31:0]              value_reg;
    logic [mt_pkg::IDX_W-1:0] idx_reg;

    logic [mt_pkg::IDX_W-1:0] rp_reg, rp_next;
    logic [mt_pkg::IDX_W-1:0] k_reg, k_next;
    logic [mt_pkg::IDX_W-1:0] far_reg, far_next;
    logic [31:0]              cur_reg, cur_next;
    logic                     twist_after_reg, twist_after_next;

    logic        out_valid_reg;
    logic [31:0] out_word_reg;

    logic        seed_start;
    logic [31:0] seed_val;
    logic        out_load;
    logic        in_accept;

    logic [mt_pkg::IDX_W:0]   nxt_sum;
    logic [mt_pkg::IDX_W-1:0] nxt_addr;
    logic [mt_pkg::IDX_W-1:0] far_addr;
    logic [31:0]              tw_y;
    logic [31:0]              tw_word;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & mt_pkg::TEMPER_B);
        y = y ^ ((y << 15) & mt_pkg::TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    mt_state_ram u_ram (
        .clk  (clk),
        .req  (ram_req),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    mt_seeder u_seeder (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seed_start),
        .seed  (seed_val),
        .wr    (seed_wr)
    );

    assign in_accept = in_valid & ~in_stall;

    // twist step k: reads for k+1 go out while k is written back
    assign nxt_sum  = {1'b0, k_reg} + 11'd2;
    assign nxt_addr = (nxt_sum >= {1'b0, mt_pkg::STATE_WORDS}) ?
                      mt_pkg::IDX_W'(nxt_sum - {1'b0, mt_pkg::STATE_WORDS}) :
                      nxt_sum[mt_pkg::IDX_W-1:0];
    assign far_addr = (far_reg == mt_pkg::LAST_WORD) ? '0 : far_reg + 1'b1;

    assign tw_y    = {cur_reg[31], rd_a[30:0]};
    assign tw_word = rd_b ^ {1'b0, tw_y[31:1]} ^ (tw_y[0] ? mt_pkg::TW_XOR_CONST : 32'd0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mt_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = mt_pkg::ST_DISPATCH;
                end
            end
            mt_pkg::ST_DISPATCH:
            begin
                if (mode_reg == mt_pkg::MODE_DRAW)
                begin
                    if (rp_reg == mt_pkg::POS_UNSEEDED)
                    begin
                        state_next = mt_pkg::ST_SEED;
                    end
                    else if (rp_reg == mt_pkg::STATE_WORDS)
                    begin
                        state_next = mt_pkg::ST_TW_PRIME;
                    end
                    else
                    begin
                        state_next = mt_pkg::ST_RD;
                    end
                end
                else if (mode_reg == mt_pkg::MODE_SEED)
                begin
                    state_next = mt_pkg::ST_SEED;
                end
                else
                begin
                    state_next = mt_pkg::ST_IDLE;
                end
            end
            mt_pkg::ST_SEED:
            begin
                if (seed_wr.done)
                begin
                    state_next = twist_after_reg ? mt_pkg::ST_TW_PRIME : mt_pkg::ST_IDLE;
                end
            end
            mt_pkg::ST_TW_PRIME: state_next = mt_pkg::ST_TW_LOAD;
            mt_pkg::ST_TW_LOAD:  state_next = mt_pkg::ST_TW_RUN;
            mt_pkg::ST_TW_RUN:
            begin
                if (k_reg == mt_pkg::LAST_WORD)
                begin
                    state_next = mt_pkg::ST_RD;
                end
            end
            mt_pkg::ST_RD: state_next = mt_pkg::ST_OUT;
            mt_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = mt_pkg::ST_IDLE;
                end
            end
            default: state_next = mt_pkg::ST_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        in_stall        = (state_reg != mt_pkg::ST_IDLE);
        seed_start      = 1'b0;
        seed_val        = value_reg;
        out_load        = 1'b0;
        ram_req.we      = 1'b0;
        ram_req.waddr   = idx_reg;
        ram_req.wdata   = value_reg;
        ram_req.raddr_a = rp_reg;
        ram_req.raddr_b = far_reg;
        case (state_reg)
            mt_pkg::ST_DISPATCH:
            begin
                if (mode_reg == mt_pkg::MODE_DRAW)
                begin
                    seed_start = (rp_reg == mt_pkg::POS_UNSEEDED);
                    seed_val   = mt_pkg::DEFAULT_SEED;
                end
                else if (mode_reg == mt_pkg::MODE_SEED)
                begin
                    seed_start = 1'b1;
                end
                else if (mode_reg == mt_pkg::MODE_LOAD)
                begin
                    ram_req.we = (idx_reg < mt_pkg::STATE_WORDS);
                end
            end
            mt_pkg::ST_SEED:
            begin
                ram_req.we    = seed_wr.we;
                ram_req.waddr = seed_wr.addr;
                ram_req.wdata = seed_wr.data;
            end
            mt_pkg::ST_TW_PRIME:
            begin
                ram_req.raddr_a = '0;
            end
            mt_pkg::ST_TW_LOAD:
            begin
                ram_req.raddr_a = 10'd1;
                ram_req.raddr_b = mt_pkg::TWIST_OFFSET;
            end
            mt_pkg::ST_TW_RUN:
            begin
                ram_req.we      = 1'b1;
                ram_req.waddr   = k_reg;
                ram_req.wdata   = tw_word;
                ram_req.raddr_a = nxt_addr;
                ram_req.raddr_b = far_addr;
            end
            mt_pkg::ST_OUT:
            begin
                out_load = ~out_valid_reg | ~out_stall;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        rp_next          = rp_reg;
        k_next           = k_reg;
        far_next         = far_reg;
        cur_next         = cur_reg;
        twist_after_next = twist_after_reg;
        case (state_reg)
            mt_pkg::ST_DISPATCH:
            begin
                twist_after_next = (mode_reg == mt_pkg::MODE_DRAW);
                if (mode_reg == mt_pkg::MODE_LOAD && idx_reg < mt_pkg::STATE_WORDS)
                begin
                    rp_next = mt_pkg::STATE_WORDS;
                end
            end
            mt_pkg::ST_SEED:
            begin
                if (seed_wr.done)
                begin
                    rp_next = mt_pkg::STATE_WORDS;
                end
            end
            mt_pkg::ST_TW_LOAD:
            begin
                cur_next = rd_a;
                k_next   = '0;
                far_next = mt_pkg::TWIST_OFFSET;
            end
            mt_pkg::ST_TW_RUN:
            begin
                cur_next = rd_a;
                k_next   = k_reg + 1'b1;
                far_next = far_addr;
                if (k_reg == mt_pkg::LAST_WORD)
                begin
                    rp_next = '0;
                end
            end
            mt_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    rp_next = rp_reg + 1'b1;
                end
            end
            default:
            begin
                rp_next = rp_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mt_pkg::ST_IDLE;
            rp_reg          <= mt_pkg::POS_UNSEEDED;
            k_reg           <= '0;
            twist_after_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rp_reg          <= rp_next;
            k_reg           <= k_next;
            twist_after_reg <= twist_after_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        far_reg <= far_next;
        cur_reg <= cur_next;
        if (in_accept)
        begin
            mode_reg  <= mode;
            value_reg <= value;
            idx_reg   <= word_index;
        end
        if (out_load)
        begin
            out_word_reg <= temper(rd_a);
        end
    end

    assign out_valid   = out_valid_reg;
    assign random_word = out_word_reg;

`ifndef SYNTHESIS
    // twist write-back never collides with either read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mt_pkg::ST_TW_RUN |->
            ram_req.waddr != ram_req.raddr_a && ram_req.waddr != ram_req.raddr_b)
    else $error("twist write overlaps a read address");

    // seeder writes only while the controller waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        seed_wr.we |-> state_reg == mt_pkg::ST_SEED)
    else $error("seeder write outside seed state");

    // a draw reads only a word that the last twist produced
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mt_pkg::ST_RD |-> rp_reg < mt_pkg::STATE_WORDS)
    else $error("draw read position out of range");

    // a new output word never overwrites one still held by the receiver
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !(out_valid_reg && out_stall))
    else $error("output word overwritten while stalled");

    // the twist pass always ends at the last word and rewinds the read position
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mt_pkg::ST_TW_RUN && state_next == mt_pkg::ST_RD |=> rp_reg == '0)
    else $error("read position not rewound after twist");
`endif

endmodule

/* rtl/mt_state_ram.sv */
// State word memory: one write port, two registered read ports.
module mt_state_ram (
    input  logic                clk,
    input  mt_pkg::mt_ram_req_t req,
    output logic [31:0]         rd_a,
    output logic [31:0]         rd_b
);

    logic [31:0] mem [0:623];
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_a_reg <= mem[req.raddr_a];
        rd_b_reg <= mem[req.raddr_b];
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

/* rtl/mt_seeder.sv */
// Seed sequencer: 69069 congruential steps, two steps per state word.
module mt_seeder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [31:0]         seed,
    output mt_pkg::mt_seed_wr_t wr
);

    logic                     busy_reg;
    logic                     phase_reg;
    logic [mt_pkg::IDX_W-1:0] cnt_reg;
    logic [31:0]              s_reg;
    logic [15:0]              hi_reg;
    logic [31:0]              s_step;

    assign s_step = s_reg * mt_pkg::LCG_MUL + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (busy_reg)
        begin
            phase_reg <= ~phase_reg;
            if (phase_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == mt_pkg::LAST_WORD)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s_reg <= seed;
        end
        else if (busy_reg)
        begin
            s_reg <= s_step;
            if (!phase_reg)
            begin
                hi_reg <= s_reg[31:16];
            end
        end
    end

    // high half from the state before the word's first step, low half from the state after it
    assign wr.we   = busy_reg & phase_reg;
    assign wr.addr = cnt_reg;
    assign wr.data = {hi_reg, s_reg[31:16]};
    assign wr.done = busy_reg & phase_reg & (cnt_reg == mt_pkg::LAST_WORD);

endmodule
